// ----- hdl/prbc_pkg.sv -----
`default_nettype none

package prbc_pkg;

    // fixed field widths
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int BF_W     = 2;
    localparam int SKIP_W   = 11;
    localparam int BYTE_W   = 8;
    localparam int PIX_W    = 16;
    localparam int SUM_W    = 18;

    localparam int DIM_LIMIT_DEF = 4096;

    localparam logic [PIX_W-1:0] SAT_MAX = 16'hFFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIN_FACTOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_SKIP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_ROW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd4;

    // reset values
    localparam logic [BF_W-1:0]   RST_BIN_FACTOR = 2'd1;
    localparam logic [SKIP_W-1:0] RST_LEAD_SKIP  = 11'd0;
    localparam logic [CFG_W-1:0]  RST_RAW_ROW    = 12'd3584;
    localparam logic [CFG_W-1:0]  RST_FRAME_ROWS = 12'd2574;
    localparam logic [CFG_W-1:0]  RST_OUT_WIDTH  = 12'd3584;

endpackage

`default_nettype wire

// ----- hdl/pixel_row_binning_crop_core.sv -----
// Horizontal pixel binning with a centered crop window. Each input word is one
// sensor pixel, high byte first. Leading pixels of a frame are dropped, each
// row is summed in groups of 1 to 3 pixels (saturating at 65535), and only the
// centered window of out_width binned pixels is emitted; the final pixel of a
// frame carries frame_last. Throughput is one word per clock unless the output
// stalls; a word passes through the input register and then the output register,
// with the binning counters and adder between them. The user must write registers
// through a plain write port only while the stream is idle; the block does not enforce it.
`default_nettype none

module pixel_row_binning_crop_core #(
    parameter int DIM_LIMIT = prbc_pkg::DIM_LIMIT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [prbc_pkg::BYTE_W-1:0]    i_byte_first,
    input  wire logic [prbc_pkg::BYTE_W-1:0]    i_byte_second,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [prbc_pkg::PIX_W-1:0]          o_pixel_value,
    output logic                                o_frame_last,
    input  wire logic                           i_cfg_we,
    input  wire logic [prbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [prbc_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int DW = $clog2(DIM_LIMIT);

    logic [prbc_pkg::BF_W-1:0]   bf;
    logic [prbc_pkg::SKIP_W-1:0] lead_skip;
    logic [DW-1:0]               rw, rows, used, left, win_end;

    logic                        r_in_valid;
    logic [prbc_pkg::BYTE_W-1:0] r_byte_first, r_byte_second;
    logic                        r_out_valid;
    logic [prbc_pkg::PIX_W-1:0]  r_pixel_value;
    logic                        r_frame_last;

    logic                        advance;
    logic                        emit;
    logic [prbc_pkg::PIX_W-1:0]  pixel_value;
    logic                        frame_last;

    prbc_cfg #(.DIM_LIMIT(DIM_LIMIT)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_bf        (bf),
        .o_lead_skip (lead_skip),
        .o_rw        (rw),
        .o_rows      (rows),
        .o_used      (used),
        .o_left      (left),
        .o_win_end   (win_end)
    );

    prbc_bin #(.DIM_LIMIT(DIM_LIMIT)) u_bin (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_byte_first  (r_byte_first),
        .i_byte_second (r_byte_second),
        .i_bf          (bf),
        .i_lead_skip   (lead_skip),
        .i_rw          (rw),
        .i_rows        (rows),
        .i_used        (used),
        .i_left        (left),
        .i_win_end     (win_end),
        .o_emit        (emit),
        .o_pixel_value (pixel_value),
        .o_frame_last  (frame_last)
    );

    // the held word moves on once the output register is free or being drained
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte_first  <= i_byte_first;
            r_byte_second <= i_byte_second;
        end
        if (advance && emit) begin
            r_pixel_value <= pixel_value;
            r_frame_last  <= frame_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_value = r_pixel_value;
    assign o_frame_last  = r_frame_last;

`ifndef SYNTHESIS
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_byte_first)
                                   && $stable(r_byte_second))
        else $error("held input word lost");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_ready)
        else $error("ready low with empty input register");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_ready && !advance |=> !r_out_valid)
        else $error("output word repeated");

    a_no_emit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |-> !advance)
        else $error("pipeline advanced over a stalled result");
`endif

endmodule

`default_nettype wire

// ----- hdl/prbc_cfg.sv -----
`default_nettype none

module prbc_cfg #(
    parameter int DIM_LIMIT = prbc_pkg::DIM_LIMIT_DEF,
    localparam int DW = $clog2(DIM_LIMIT)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [prbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [prbc_pkg::CFG_W-1:0]     i_cfg_data,
    output logic [prbc_pkg::BF_W-1:0]           o_bf,
    output logic [prbc_pkg::SKIP_W-1:0]         o_lead_skip,
    output logic [DW-1:0]                       o_rw,
    output logic [DW-1:0]                       o_rows,
    output logic [DW-1:0]                       o_used,
    output logic [DW-1:0]                       o_left,
    output logic [DW-1:0]                       o_win_end
);

    localparam int XW  = (DW > prbc_pkg::CFG_W) ? DW : prbc_pkg::CFG_W;
    localparam int LIM = DIM_LIMIT - 1;
    // reciprocal of 3, one correction step after the multiply
    localparam int S   = DW + 2;
    localparam logic [S-1:0] K3 = S'((2 ** S) / 3);

    logic [prbc_pkg::BF_W-1:0]   r_bin_factor;
    logic [prbc_pkg::SKIP_W-1:0] r_lead_skip;
    logic [prbc_pkg::CFG_W-1:0]  r_raw_row;
    logic [prbc_pkg::CFG_W-1:0]  r_frame_rows;
    logic [prbc_pkg::CFG_W-1:0]  r_out_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_factor <= prbc_pkg::RST_BIN_FACTOR;
            r_lead_skip  <= prbc_pkg::RST_LEAD_SKIP;
            r_raw_row    <= prbc_pkg::RST_RAW_ROW;
            r_frame_rows <= prbc_pkg::RST_FRAME_ROWS;
            r_out_width  <= prbc_pkg::RST_OUT_WIDTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                prbc_pkg::REG_BIN_FACTOR: r_bin_factor <= i_cfg_data[prbc_pkg::BF_W-1:0];
                prbc_pkg::REG_LEAD_SKIP:  r_lead_skip  <= i_cfg_data[prbc_pkg::SKIP_W-1:0];
                prbc_pkg::REG_RAW_ROW:    r_raw_row    <= i_cfg_data;
                prbc_pkg::REG_FRAME_ROWS: r_frame_rows <= i_cfg_data;
                prbc_pkg::REG_OUT_WIDTH:  r_out_width  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [DW-1:0] clamp_dim(input logic [prbc_pkg::CFG_W-1:0] v,
                                                 input logic zero_is_one);
        logic [XW-1:0] x;
        x = XW'(v);
        if (zero_is_one && x == '0) x = XW'(1);
        if (x > XW'(LIM)) x = XW'(LIM);
        return x[DW-1:0];
    endfunction

    logic [DW-1:0]   rw, ow, bw, q0, q3, win;
    logic [DW+S-1:0] prod;
    logic [DW+1:0]   three_q, rem;
    logic [DW+1:0]   used_w;

    assign o_bf        = (r_bin_factor == '0) ? prbc_pkg::BF_W'(1) : r_bin_factor;
    assign o_lead_skip = r_lead_skip;
    assign rw          = clamp_dim(r_raw_row, 1'b1);
    assign o_rw        = rw;
    assign o_rows      = clamp_dim(r_frame_rows, 1'b1);
    assign ow          = clamp_dim(r_out_width, 1'b0);

    assign prod    = (DW+S)'(rw) * (DW+S)'(K3);
    assign q0      = prod[DW+S-1:S];
    assign three_q = {1'b0, q0, 1'b0} + (DW+2)'(q0);
    assign rem     = (DW+2)'(rw) - three_q;
    assign q3      = (rem >= (DW+2)'(3)) ? q0 + 1'b1 : q0;

    always_comb begin
        case (o_bf)
            2'd1: begin
                bw     = rw;
                used_w = (DW+2)'(rw);
            end
            2'd2: begin
                bw     = {1'b0, rw[DW-1:1]};
                used_w = (DW+2)'({bw, 1'b0});
            end
            default: begin
                bw     = q3;
                used_w = (DW+2)'({bw, 1'b0}) + (DW+2)'(bw);
            end
        endcase
    end

    assign o_used    = used_w[DW-1:0];
    assign win       = (ow < bw) ? ow : bw;
    assign o_left    = (bw - win) >> 1;
    assign o_win_end = o_left + win;

endmodule

`default_nettype wire

// ----- hdl/prbc_bin.sv -----
`default_nettype none

module prbc_bin #(
    parameter int DIM_LIMIT = prbc_pkg::DIM_LIMIT_DEF,
    localparam int DW = $clog2(DIM_LIMIT)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic [prbc_pkg::BYTE_W-1:0] i_byte_first,
    input  wire logic [prbc_pkg::BYTE_W-1:0] i_byte_second,
    input  wire logic [prbc_pkg::BF_W-1:0]   i_bf,
    input  wire logic [prbc_pkg::SKIP_W-1:0] i_lead_skip,
    input  wire logic [DW-1:0]               i_rw,
    input  wire logic [DW-1:0]               i_rows,
    input  wire logic [DW-1:0]               i_used,
    input  wire logic [DW-1:0]               i_left,
    input  wire logic [DW-1:0]               i_win_end,
    output logic                             o_emit,
    output logic [prbc_pkg::PIX_W-1:0]       o_pixel_value,
    output logic                             o_frame_last
);

    logic                        r_active,   n_active;
    logic [prbc_pkg::SKIP_W-1:0] r_skip,     n_skip;
    logic [DW-1:0]               r_raw_col,  n_raw_col;
    logic [prbc_pkg::BF_W-1:0]   r_phase,    n_phase;
    logic [prbc_pkg::SUM_W-1:0]  r_sum,      n_sum;
    logic [DW-1:0]               r_bin_col,  n_bin_col;
    logic [DW-1:0]               r_row,      n_row;

    logic [prbc_pkg::SKIP_W-1:0] skip_cur;
    logic [prbc_pkg::PIX_W-1:0]  pix;
    logic [prbc_pkg::SUM_W-1:0]  sum_add;
    logic [prbc_pkg::BF_W-1:0]   phase_add;
    logic [DW:0]                 raw_next;
    logic                        in_window;

    assign skip_cur  = r_active ? r_skip : i_lead_skip;
    assign pix       = {i_byte_first, i_byte_second};
    assign sum_add   = r_sum + prbc_pkg::SUM_W'(pix);
    assign phase_add = r_phase + 1'b1;
    assign raw_next  = (DW+1)'(r_raw_col) + 1'b1;
    assign in_window = (r_bin_col >= i_left) && (r_bin_col < i_win_end);

    always_comb begin
        n_active      = r_active;
        n_skip        = r_skip;
        n_raw_col     = r_raw_col;
        n_phase       = r_phase;
        n_sum         = r_sum;
        n_bin_col     = r_bin_col;
        n_row         = r_row;
        o_emit        = 1'b0;
        o_frame_last  = (r_row == i_rows - 1'b1) && (r_bin_col == i_win_end - 1'b1);
        o_pixel_value = (sum_add > prbc_pkg::SUM_W'(prbc_pkg::SAT_MAX)) ?
                        prbc_pkg::SAT_MAX : sum_add[prbc_pkg::PIX_W-1:0];
        if (i_en) begin
            n_active = 1'b1;
            if (skip_cur != '0) begin
                n_skip = skip_cur - 1'b1;
            end else begin
                n_skip = skip_cur;
                if (r_raw_col < i_used) begin
                    if (phase_add >= i_bf) begin
                        o_emit    = in_window;
                        n_bin_col = r_bin_col + 1'b1;
                        n_sum     = '0;
                        n_phase   = '0;
                    end else begin
                        n_sum   = sum_add;
                        n_phase = phase_add;
                    end
                end
                n_raw_col = raw_next[DW-1:0];
                // end of row: clear group state, step row, close frame after last row
                if (raw_next >= (DW+1)'(i_rw)) begin
                    n_raw_col = '0;
                    n_bin_col = '0;
                    n_sum     = '0;
                    n_phase   = '0;
                    n_row     = r_row + 1'b1;
                    if ((DW+1)'(r_row) + 1'b1 >= (DW+1)'(i_rows)) begin
                        n_row    = '0;
                        n_active = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_skip    <= '0;
            r_raw_col <= '0;
            r_phase   <= '0;
            r_sum     <= '0;
            r_bin_col <= '0;
            r_row     <= '0;
        end else begin
            r_active  <= n_active;
            r_skip    <= n_skip;
            r_raw_col <= n_raw_col;
            r_phase   <= n_phase;
            r_sum     <= n_sum;
            r_bin_col <= n_bin_col;
            r_row     <= n_row;
        end
    end

endmodule

`default_nettype wire

// ----- bench/pixel_row_binning_crop_core_tb.sv -----
`timescale 1ns / 1ps

module pixel_row_binning_crop_core_tb;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int DIM_MAX       = prbc_pkg::DIM_LIMIT_DEF - 1;
    localparam int BIG_SKIP      = 400;

    typedef logic [prbc_pkg::CFG_IDX_W-1:0] t_reg_idx;

    typedef struct packed {
        logic [prbc_pkg::PIX_W-1:0] value;
        logic                       frame_end;
    } t_binned_pixel;

    // Mirrors the binning/crop counters and holds the binned pixels still owed.
    class binned_row_checker;
        logic [prbc_pkg::BF_W-1:0]   bin_factor;
        logic [prbc_pkg::SKIP_W-1:0] lead_skip;
        logic [prbc_pkg::CFG_W-1:0]  row_len;
        logic [prbc_pkg::CFG_W-1:0]  frame_len;
        logic [prbc_pkg::CFG_W-1:0]  crop_len;
        int                          skip_left;
        int                          raw_col;
        int                          group_fill;
        int                          group_acc;
        int                          bin_col;
        int                          row_idx;
        bit                          in_frame;
        t_binned_pixel               binned_due[$];
        int                          mismatches;

        function new();
            bin_factor = prbc_pkg::RST_BIN_FACTOR;
            lead_skip  = prbc_pkg::RST_LEAD_SKIP;
            row_len    = prbc_pkg::RST_RAW_ROW;
            frame_len  = prbc_pkg::RST_FRAME_ROWS;
            crop_len   = prbc_pkg::RST_OUT_WIDTH;
            skip_left  = 0;
            raw_col    = 0;
            group_fill = 0;
            group_acc  = 0;
            bin_col    = 0;
            row_idx    = 0;
            in_frame   = 1'b0;
            mismatches = 0;
        endfunction

        function int dim_clamp(int v);
            if (v == 0) return 1;
            return (v > DIM_MAX) ? DIM_MAX : v;
        endfunction

        function void set_reg(t_reg_idx idx, logic [prbc_pkg::CFG_W-1:0] data);
            case (idx)
                prbc_pkg::REG_BIN_FACTOR: bin_factor = data[prbc_pkg::BF_W-1:0];
                prbc_pkg::REG_LEAD_SKIP:  lead_skip  = data[prbc_pkg::SKIP_W-1:0];
                prbc_pkg::REG_RAW_ROW:    row_len    = data;
                prbc_pkg::REG_FRAME_ROWS: frame_len  = data;
                prbc_pkg::REG_OUT_WIDTH:  crop_len   = data;
                default: ;
            endcase
        endfunction

        function void take_raw_pixel(logic [prbc_pkg::BYTE_W-1:0] hi,
                                     logic [prbc_pkg::BYTE_W-1:0] lo);
            int            bf;
            int            rw;
            int            nrows;
            int            ow;
            int            bw;
            int            win;
            int            margin;
            t_binned_pixel res;
            bf     = (bin_factor == '0) ? 1 : int'(bin_factor);
            rw     = dim_clamp(int'(row_len));
            nrows  = dim_clamp(int'(frame_len));
            ow     = (int'(crop_len) > DIM_MAX) ? DIM_MAX : int'(crop_len);
            bw     = rw / bf;
            win    = (ow < bw) ? ow : bw;
            margin = (bw - win) / 2;

            // skip count is only reloaded when a new frame begins
            if (!in_frame) begin
                skip_left = int'(lead_skip);
                in_frame  = 1'b1;
            end
            if (skip_left > 0) begin
                skip_left--;
                return;
            end

            if (raw_col < bw * bf) begin
                group_acc += int'({hi, lo});
                group_fill++;
                if (group_fill >= bf) begin
                    if (bin_col >= margin && bin_col < margin + win) begin
                        res.value     = (group_acc > int'(prbc_pkg::SAT_MAX)) ?
                                        prbc_pkg::SAT_MAX : group_acc[prbc_pkg::PIX_W-1:0];
                        res.frame_end = (row_idx == nrows - 1) && (bin_col == margin + win - 1);
                        binned_due.push_back(res);
                    end
                    bin_col++;
                    group_acc  = 0;
                    group_fill = 0;
                end
            end

            raw_col++;
            if (raw_col >= rw) begin
                raw_col    = 0;
                bin_col    = 0;
                group_acc  = 0;
                group_fill = 0;
                row_idx++;
                if (row_idx >= nrows) begin
                    row_idx  = 0;
                    in_frame = 1'b0;
                end
            end
        endfunction

        function void check_binned_pixel(logic [prbc_pkg::PIX_W-1:0] value, logic frame_end);
            t_binned_pixel want;
            if (binned_due.size() == 0) begin
                $error("unexpected word: pixel_value=%0d frame_last=%0b", value, frame_end);
                mismatches++;
                return;
            end
            want = binned_due.pop_front();
            if (value !== want.value) begin
                $error("pixel_value: expected %0d, actual %0d", want.value, value);
                mismatches++;
            end
            if (frame_end !== want.frame_end) begin
                $error("frame_last: expected %0b, actual %0b", want.frame_end, frame_end);
                mismatches++;
            end
        endfunction

        function int pending();
            return binned_due.size();
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    logic [prbc_pkg::BYTE_W-1:0]         i_byte_first;
    logic [prbc_pkg::BYTE_W-1:0]         i_byte_second;
    logic                                o_valid;
    logic                                i_ready;
    logic [prbc_pkg::PIX_W-1:0]          o_pixel_value;
    logic                                o_frame_last;
    logic                                i_cfg_we;
    logic [prbc_pkg::CFG_IDX_W-1:0]      i_cfg_idx;
    logic [prbc_pkg::CFG_W-1:0]          i_cfg_data;

    bit calm;
    bit hold_req;
    int idle_cycles = 0;
    int random_sent;

    binned_row_checker board = new();

    pixel_row_binning_crop_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_byte_first  (i_byte_first),
        .i_byte_second (i_byte_second),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_value (o_pixel_value),
        .o_frame_last  (o_frame_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int short_or_long();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [prbc_pkg::BYTE_W-1:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return prbc_pkg::BYTE_W'($urandom);
    endfunction

    task automatic send_pixel(input logic [prbc_pkg::BYTE_W-1:0] hi,
                              input logic [prbc_pkg::BYTE_W-1:0] lo);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 65) ? 0 : short_or_long();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_byte_first  <= hi;
        i_byte_second <= lo;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_pixel(rand_byte(), rand_byte());
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [prbc_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        board.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mask bit order follows the register indexes
    task automatic apply_setting(input int bf, input int skip, input int row, input int rows,
                                 input int width, input logic [4:0] mask);
        if (mask[prbc_pkg::REG_BIN_FACTOR])
            write_reg(prbc_pkg::REG_BIN_FACTOR, prbc_pkg::CFG_W'(bf));
        if (mask[prbc_pkg::REG_LEAD_SKIP])
            write_reg(prbc_pkg::REG_LEAD_SKIP, prbc_pkg::CFG_W'(skip));
        if (mask[prbc_pkg::REG_RAW_ROW])
            write_reg(prbc_pkg::REG_RAW_ROW, prbc_pkg::CFG_W'(row));
        if (mask[prbc_pkg::REG_FRAME_ROWS])
            write_reg(prbc_pkg::REG_FRAME_ROWS, prbc_pkg::CFG_W'(rows));
        if (mask[prbc_pkg::REG_OUT_WIDTH])
            write_reg(prbc_pkg::REG_OUT_WIDTH, prbc_pkg::CFG_W'(width));
    endtask

    // dropped words give no result, so let the pipe empty after the last one
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int stall_left;
        int hold_cnt;
        i_ready    = 1'b0;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < 20) begin
                i_ready <= 1'b0;
                stall_left = short_or_long() - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) board.take_raw_pixel(i_byte_first, i_byte_second);
            if (o_valid && i_ready) board.check_binned_pixel(o_pixel_value, o_frame_last);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("pixel_row_binning_crop_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int n_items;
        int bf_v;
        int skip_v;
        int row_v;
        int rows_v;
        int width_v;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_byte_first  = '0;
        i_byte_second = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = prbc_pkg::REG_BIN_FACTOR;
        i_cfg_data    = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one centered pixel per row, byte order extremes
        apply_setting(1, 0, 3, 2, 1, '1);
        send_pixel(8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF);
        send_pixel(8'h00, 8'hFF);
        send_pixel(8'hFF, 8'h00);
        send_pixel(8'hA5, 8'h5A);
        send_pixel(8'h5A, 8'hA5);
        drain();

        // full-scale triples saturate, crop clamps to binned width, tail pixel dropped
        apply_setting(3, 0, 7, 1, DIM_MAX, '1);
        repeat (7) send_pixel(8'hFF, 8'hFF);
        drain();

        // zero bin factor and zero sizes act as one; two words skipped per frame
        apply_setting(0, 2, 0, 0, 1, '1);
        send_random(6);
        drain();

        // empty crop window
        apply_setting(2, 0, 3, 2, 0, '1);
        send_random(6);
        drain();

        // row shorter than one group
        apply_setting(3, 0, 2, 2, 4, '1);
        send_random(4);
        drain();

        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if (phase == 1) begin
                // receiver holds off long enough for the input side to back up
                calm = 1'b1;
                apply_setting(1, 0, 16, 4, DIM_MAX, '1);
                hold_req = 1'b1;
                n_items  = 80;
                send_random(n_items);
            end else if (phase == 4) begin
                // long row of triples with a dropped tail pixel, narrow centered window
                apply_setting(3, 0, 301, 1, 40, '1);
                n_items = 306;
                send_random(n_items);
            end else if (phase == 7) begin
                apply_setting(1, BIG_SKIP, 5, 1, 5, '1);
                n_items = BIG_SKIP + 60;
                send_random(n_items);
            end else begin
                bf_v    = $urandom_range(0, 3);
                skip_v  = ($urandom_range(0, 9) < 6) ? 0 :
                          ($urandom_range(0, 3) < 3) ? $urandom_range(1, 8)
                                                     : $urandom_range(9, 60);
                row_v   = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 16)
                                                       : $urandom_range(17, 80);
                rows_v  = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 4)
                                                       : $urandom_range(5, 12);
                width_v = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 16) :
                          ($urandom_range(0, 1) == 0) ? DIM_MAX : $urandom_range(0, DIM_MAX);
                apply_setting(bf_v, skip_v, row_v, rows_v, width_v, 5'($urandom));
                n_items = $urandom_range(20, 90);
                send_random(n_items);
            end
            random_sent += n_items;
            drain();
            phase++;
        end

        if (board.mismatches == 0) begin
            $display("pixel_row_binning_crop_core regression: pass");
        end else begin
            $display("pixel_row_binning_crop_core regression: fail");
        end
        $finish;
    end

endmodule
